### sv/direct_form_fir_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// direct form fir filter assertion macros
// shared property shapes for the concurrent checks of the filter
// ----------------------------------------------------------------------------
`ifndef DIRECT_FORM_FIR_FILTER_UNIT_MACROS_SVH
`define DIRECT_FORM_FIR_FILTER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DFIR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfir same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define DFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfir next-cycle check failed");

`endif

### sv/dfir_pkg.sv
// ----------------------------------------------------------------------------
// dfir package
// widths, codes and controller types of the direct form fir filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfir_pkg;

    localparam int CMD_W        = 2;
    localparam int TAP_INDEX_W  = 10;
    localparam int TAP_VALUE_W  = 18;
    localparam int SAMPLE_W     = 16;
    localparam int FILTERED_W   = 44;
    localparam int TAPS_W       = 11;
    localparam int PROD_W       = TAP_VALUE_W + SAMPLE_W;

    localparam int MAX_TAPS_DEFAULT = 1024;
    localparam logic [TAPS_W-1:0] TAPS_RESET = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_FILTER = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_coef;
        logic start_sample;
        logic clear_hist;
        logic issue;
        logic load_out;
    } dfir_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dfir_sts_t;

endpackage

`default_nettype wire

### sv/dfir_in_if.sv
// ----------------------------------------------------------------------------
// dfir input channel
// valid/ready channel carrying one command word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dfir_in_if
    import dfir_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [CMD_W-1:0]              cmd;
    logic [TAP_INDEX_W-1:0]        tap_index;
    logic signed [TAP_VALUE_W-1:0] tap_value;
    logic signed [SAMPLE_W-1:0]    sample;

    modport source (output valid, output cmd, output tap_index, output tap_value,
                    output sample, input ready);
    modport sink   (input valid, input cmd, input tap_index, input tap_value,
                    input sample, output ready);
endinterface

`default_nettype wire

### sv/dfir_out_if.sv
// ----------------------------------------------------------------------------
// dfir output channel
// valid/ready channel carrying one filtered word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dfir_out_if
    import dfir_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [FILTERED_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

### sv/dfir_ctrl.sv
// ----------------------------------------------------------------------------
// dfir controller
// command decode, tap loop count and result hand-off sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfir_ctrl
    import dfir_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [TAPS_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    input  wire logic [CMD_W-1:0]  in_code,
    output logic                   in_ready,
    output dfir_ctl_t              ctl,
    input  wire dfir_sts_t         sts
);

    localparam int CNT_W = ($clog2(MAX_TAPS + 1) > TAPS_W) ? $clog2(MAX_TAPS + 1) : TAPS_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TAPS);

    state_t            state_reg, state_next;
    logic [TAPS_W-1:0] taps_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  taps_ext;
    logic [CNT_W-1:0]  taps_eff;

    assign taps_ext = CNT_W'(taps_reg);
    assign taps_eff = (taps_ext > MAX_CNT) ? MAX_CNT : taps_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            taps_reg  <= TAPS_RESET;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                taps_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (cmd_e_t'(in_code))
                        CMD_LOAD:
                        begin
                            ctl.load_coef = 1'b1;
                        end
                        CMD_FILTER:
                        begin
                            ctl.start_sample = 1'b1;
                            cnt_next         = taps_eff;
                            // empty sum goes straight to hand-off
                            state_next = (taps_eff == '0) ? ST_FINISH : ST_ISSUE;
                        end
                        CMD_CLEAR:
                        begin
                            ctl.clear_hist = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                ctl.issue = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/dfir_datapath.sv
// ----------------------------------------------------------------------------
// dfir datapath
// tap and history stores, shared multiply-accumulate and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfir_datapath
    import dfir_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dfir_ctl_t                     ctl,
    output dfir_sts_t                          sts,
    input  wire logic [TAP_INDEX_W-1:0]        tap_index,
    input  wire logic signed [TAP_VALUE_W-1:0] tap_value,
    input  wire logic signed [SAMPLE_W-1:0]    sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [FILTERED_W-1:0]       filtered
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W = ($clog2(MAX_TAPS + 1) > TAPS_W) ? $clog2(MAX_TAPS + 1) : TAPS_W;
    // one spare bit so the store size itself fits in the compare
    localparam int IXW   = ((AW > TAP_INDEX_W) ? AW : TAP_INDEX_W) + 1;
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_TAPS);
    localparam logic [AW-1:0]    LAST_POS = AW'(MAX_TAPS - 1);

    logic signed [TAP_VALUE_W-1:0] coef_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0]    hist_mem [MAX_TAPS];

    logic [IXW-1:0] load_ix;
    logic           coef_we;

    logic [AW-1:0]    ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [AW-1:0]    k_reg;
    logic [AW-1:0]    pos_reg;

    logic signed [TAP_VALUE_W-1:0] coef_rd_reg;
    logic signed [SAMPLE_W-1:0]    hist_rd_reg;
    logic                          s1_vld_reg;
    logic                          s1_live_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          s2_vld_reg;
    logic signed [FILTERED_W-1:0]  acc_reg;
    logic signed [FILTERED_W-1:0]  filtered_reg;
    logic                          out_vld_reg;

    assign load_ix = IXW'(tap_index);
    // loads past the end of the store are dropped
    assign coef_we = ctl.load_coef && (load_ix < IXW'(MAX_TAPS));

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[load_ix[AW-1:0]] <= tap_value;
        end
        if (ctl.issue)
        begin
            coef_rd_reg <= coef_mem[k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start_sample)
        begin
            hist_mem[ptr_reg] <= sample;
        end
        if (ctl.issue)
        begin
            hist_rd_reg <= hist_mem[pos_reg];
        end
    end

    // fill count stands in for zeroing: slots older than the fill read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            fill_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear_hist)
            begin
                ptr_reg  <= '0;
                fill_reg <= '0;
            end
            else if (ctl.start_sample)
            begin
                ptr_reg  <= (ptr_reg == LAST_POS) ? '0 : ptr_reg + 1'b1;
                fill_reg <= (fill_reg == MAX_CNT) ? MAX_CNT : fill_reg + 1'b1;
            end
            s1_vld_reg <= ctl.issue;
            s2_vld_reg <= s1_vld_reg;
            if (ctl.load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start_sample)
        begin
            k_reg   <= '0;
            pos_reg <= ptr_reg;
            acc_reg <= '0;
        end
        else if (ctl.issue)
        begin
            k_reg   <= k_reg + 1'b1;
            pos_reg <= (pos_reg == '0) ? LAST_POS : pos_reg - 1'b1;
        end
        if (ctl.issue)
        begin
            s1_live_reg <= CNT_W'(k_reg) < fill_reg;
        end
        if (s1_live_reg)
        begin
            prod_reg <= coef_rd_reg * hist_rd_reg;
        end
        else
        begin
            prod_reg <= '0;
        end
        if (s2_vld_reg && !ctl.start_sample)
        begin
            acc_reg <= acc_reg + FILTERED_W'(prod_reg);
        end
        if (ctl.load_out)
        begin
            filtered_reg <= acc_reg;
        end
    end

    assign sts.pipe_busy = s1_vld_reg || s2_vld_reg;
    assign sts.out_free  = !out_vld_reg || out_ready;
    assign out_valid     = out_vld_reg;
    assign filtered      = filtered_reg;

endmodule

`default_nettype wire

### sv/direct_form_fir_filter_unit.sv
// ----------------------------------------------------------------------------
// direct form fir filter unit
// streaming fir filter with a loadable tap store and one shared mac
// ----------------------------------------------------------------------------
//  channel   dir  payload                              per word
//  items     in   cmd, tap_index, tap_value, sample    load, filter or clear
//  results   out  filtered                             one per filter word
//  cfg       in   cfg_we, cfg_wdata                    taps_in_use write
//
//  for a filter word one mac walks the tap store one tap a cycle, then
//  waits for the mac pipeline to drain and hands the sum off
//  load and clear words are handled in the idle state
//  no clearing pass after reset: a fill count masks history never written
//  a waiting result does not block the next word; a finished sum holds
//  until the output register is free
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "direct_form_fir_filter_unit_macros.svh"

module direct_form_fir_filter_unit
    import dfir_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [TAPS_W-1:0] cfg_wdata,
    dfir_in_if.sink                items,
    dfir_out_if.source             results
);

    dfir_ctl_t ctl;
    dfir_sts_t sts;

    dfir_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (items.valid),
        .in_code   (items.cmd),
        .in_ready  (items.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    dfir_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .tap_index (items.tap_index),
        .tap_value (items.tap_value),
        .sample    (items.sample),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .filtered  (results.filtered)
    );

    // the mac pipeline is empty whenever a new word can be taken
    `DFIR_ASSERT_IMPL(a_idle_pipe_empty, clk, rst_n, items.ready, !sts.pipe_busy)
    // the output register is only loaded when it is free
    `DFIR_ASSERT_IMPL(a_load_when_free, clk, rst_n, ctl.load_out, sts.out_free)
    // a loaded sum shows as valid in the next cycle
    `DFIR_ASSERT_NEXT(a_load_shows, clk, rst_n, ctl.load_out, results.valid)
    // an accepted filter word keeps the input closed in the next cycle
    `DFIR_ASSERT_NEXT(a_filter_busy, clk, rst_n,
        items.valid && items.ready && (items.cmd == CMD_FILTER), !items.ready)

endmodule

`default_nettype wire
